FILE: rtl/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  // Fixed widths of the transaction fields and of the register port
  localparam int FIELD_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;

  localparam int OPERAND_BITS_DFLT = 16;

  // Register index, taken from paddr[2]
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_MUL  = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// From the accepting edge the unit runs one PREP pass and then one MUL pass per exponent bit
// on a pair of bit-serial modular multipliers, and then strobes done.
// A new transaction is taken only while idle, so the next one waits for the done strobe;
// the next start is taken at the edge that ends the done strobe. The receiver cannot stall.
// Reset (rst, synchronous, active high): idle, no strobe, modulus = 1, exponent = 1.

module modular_exponentiation_unit #(
  parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_DFLT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // command side
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [modexp_pkg::FIELD_BITS-1:0]  base,
  output logic                                    done,
  output logic      [modexp_pkg::FIELD_BITS-1:0]  residue,
  // register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [modexp_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [modexp_pkg::DATA_BITS-1:0]   pwdata,
  output logic      [modexp_pkg::DATA_BITS-1:0]   prdata,
  output logic                                    pready
);

  import modexp_pkg::*;

  localparam int W = OPERAND_BITS;
  localparam int CntBits = $clog2(OPERAND_BITS);
  localparam logic [CntBits-1:0] CntLast = CntBits'(OPERAND_BITS - 1);

  // One step of an MSB-first interleaved modular multiply:
  // r <- (2r + b*y) mod m, with r, y < m. Two conditional subtracts keep it narrow.
  function automatic logic [W-1:0] mod_step(input logic [W-1:0] r, input logic b,
                                            input logic [W-1:0] y, input logic [W-1:0] m);
    logic [W:0] t;
    logic [W:0] mx;
    mx = {1'b0, m};
    t = {r, 1'b0};
    if (t >= mx) t = t - mx;
    if (b) t = t + {1'b0, y};
    if (t >= mx) t = t - mx;
    return t[W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Register port: modulus at byte 0, exponent at byte 4. pready is always high.
  // ---------------------------------------------------------------------------
  logic [FIELD_BITS-1:0] modulus;
  logic [FIELD_BITS-1:0] exponent;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= FIELD_BITS'(1);
      exponent <= FIELD_BITS'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MODULUS:  modulus  <= pwdata[FIELD_BITS-1:0];
        REG_EXPONENT: exponent <= pwdata[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODULUS:  prdata = {{(DATA_BITS-FIELD_BITS){1'b0}}, modulus};
      REG_EXPONENT: prdata = {{(DATA_BITS-FIELD_BITS){1'b0}}, exponent};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Operands trimmed or zero-extended to the operand width
  // ---------------------------------------------------------------------------
  logic [W+FIELD_BITS-1:0] base_ext;
  logic [W+FIELD_BITS-1:0] mod_ext;
  logic [W+FIELD_BITS-1:0] exp_ext;
  logic [W-1:0]            mod_op;

  assign base_ext = {{W{1'b0}}, base};
  assign mod_ext  = {{W{1'b0}}, modulus};
  assign exp_ext  = {{W{1'b0}}, exponent};
  assign mod_op   = mod_ext[W-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer and datapath.
  // PREP: reduce the base, sq = base*1 mod n, scanning base one bit a cycle.
  // MUL:  per exponent bit, run acc*sq and sq*sq side by side in one pass;
  //       keep the product into acc only when the exponent bit is set.
  // ---------------------------------------------------------------------------
  state_t           state, state_next;
  logic [W-1:0]     n_r;       // latched modulus
  logic [W-1:0]     one;       // 1 mod n
  logic [W-1:0]     acc, acc_next;
  logic [W-1:0]     sq, sq_next;
  logic [W-1:0]     racc, racc_next;   // running acc*sq
  logic [W-1:0]     rsq, rsq_next;     // running sq*sq, or base reduction in PREP
  logic [W-1:0]     sacc, sacc_next;   // scanned copy of acc (of base in PREP)
  logic [W-1:0]     ssq, ssq_next;     // scanned copy of sq
  logic [W-1:0]     eshift, eshift_next;
  logic [CntBits-1:0] cnt, cnt_next;
  logic [CntBits-1:0] ecnt, ecnt_next;
  logic             done_next;
  logic [FIELD_BITS-1:0] residue_next;
  logic [W-1:0]     mcand;
  logic [W-1:0]     racc_step;
  logic [W-1:0]     rsq_step;
  logic [W-1:0]     acc_upd;
  logic [W+FIELD_BITS-1:0] res_ext;
  logic             accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // In PREP the addend is 1 mod n; afterwards it is the current square
  assign mcand     = (state == ST_PREP) ? one : sq;
  assign racc_step = mod_step(racc, sacc[W-1], mcand, n_r);
  assign rsq_step  = mod_step(rsq, (state == ST_PREP) ? sacc[W-1] : ssq[W-1], mcand, n_r);
  assign acc_upd   = eshift[0] ? racc_step : acc;
  assign res_ext   = {{FIELD_BITS{1'b0}}, acc_upd};

  always_comb begin
    state_next   = state;
    acc_next     = acc;
    sq_next      = sq;
    racc_next    = racc;
    rsq_next     = rsq;
    sacc_next    = sacc;
    ssq_next     = ssq;
    eshift_next  = eshift;
    cnt_next     = cnt;
    ecnt_next    = ecnt;
    done_next    = 1'b0;
    residue_next = residue;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PREP;
          acc_next   = (mod_op == W'(1)) ? '0 : W'(1);
          sacc_next  = base_ext[W-1:0];
          rsq_next   = '0;
          racc_next  = '0;
          eshift_next = exp_ext[W-1:0];
          cnt_next   = '0;
          ecnt_next  = '0;
        end
      end
      ST_PREP: begin
        rsq_next  = rsq_step;
        sacc_next = {sacc[W-2:0], 1'b0};
        cnt_next  = cnt + CntBits'(1);
        if (cnt == CntLast) begin
          // base reduced: load both multipliers for the first exponent bit
          state_next = ST_MUL;
          sq_next    = rsq_step;
          sacc_next  = acc;
          ssq_next   = rsq_step;
          racc_next  = '0;
          rsq_next   = '0;
          cnt_next   = '0;
        end
      end
      ST_MUL: begin
        racc_next = racc_step;
        rsq_next  = rsq_step;
        sacc_next = {sacc[W-2:0], 1'b0};
        ssq_next  = {ssq[W-2:0], 1'b0};
        cnt_next  = cnt + CntBits'(1);
        if (cnt == CntLast) begin
          acc_next    = acc_upd;
          sq_next     = rsq_step;
          sacc_next   = acc_upd;
          ssq_next    = rsq_step;
          racc_next   = '0;
          rsq_next    = '0;
          cnt_next    = '0;
          eshift_next = {1'b0, eshift[W-1:1]};
          ecnt_next   = ecnt + CntBits'(1);
          if (ecnt == CntLast) begin
            // last exponent bit: drop to idle and strobe the residue
            state_next   = ST_IDLE;
            done_next    = 1'b1;
            residue_next = (n_r == '0) ? '0 : res_ext[FIELD_BITS-1:0];
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      ecnt  <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      cnt   <= cnt_next;
      ecnt  <= ecnt_next;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      n_r <= mod_op;
      one <= (mod_op == W'(1)) ? '0 : W'(1);
    end
    acc     <= acc_next;
    sq      <= sq_next;
    racc    <= racc_next;
    rsq     <= rsq_next;
    sacc    <= sacc_next;
    ssq     <= ssq_next;
    eshift  <= eshift_next;
    residue <= residue_next;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted transaction did not start");

  a_residue_range: assert property (@(posedge clk) disable iff (rst)
      done |-> (n_r == '0) || ({{W{1'b0}}, residue} < {{FIELD_BITS{1'b0}}, n_r}))
    else $error("residue not reduced below modulus");

  a_partial_range: assert property (@(posedge clk) disable iff (rst)
      (state == ST_MUL) && (n_r != '0) |-> (racc < n_r) && (rsq < n_r) && (sq < n_r))
    else $error("serial multiplier left its residue range");
`endif

endmodule

`default_nettype wire
